/* design/pbse_pkg.sv */
package pbse_pkg;

  localparam int MaxItems = 6;
  localparam int MaxRes   = 4;
  localparam int FracBits = 16;
  localparam int ProbW    = 17;
  localparam int WeightW  = 16;
  localparam int TotalW   = 19;
  localparam int MaskW    = 6;
  localparam int ItemW    = 3;
  localparam int ResW     = 3;
  localparam int ScenN    = 64;

  localparam logic [ProbW-1:0] ProbOne = ProbW'(1) << FracBits;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             load;
    logic             calc_clr;
    logic             calc_step;
    logic             use_best;
    logic             key_wr;
    logic             scan_clr;
    logic             scan_rd;
    logic             emit;
    logic             last;
    logic             run_end;
    logic [MaskW-1:0] mask;
    logic [ItemW-1:0] item;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [ItemW-1:0] count;
  } status_t;

endpackage

/* design/pbse_ram.sv */
module pbse_ram #(
  parameter int Width = 19,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/pbse_datapath.sv */
module pbse_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pbse_pkg::cmd_t                      cmd_i,
  output pbse_pkg::status_t                   status_o,
  input  logic                                cfg_we_i,
  input  logic [pbse_pkg::ResW-1:0]           cfg_data_i,
  input  logic [pbse_pkg::ProbW-1:0]          prob_i,
  input  logic [pbse_pkg::WeightW-1:0]        win_i  [pbse_pkg::MaxRes],
  input  logic [pbse_pkg::WeightW-1:0]        loss_i [pbse_pkg::MaxRes],
  output logic                                valid_o,
  output logic [pbse_pkg::MaskW-1:0]          mask_o,
  output logic [pbse_pkg::ProbW-1:0]          prob_o,
  output logic [pbse_pkg::TotalW-1:0]         total_o [pbse_pkg::MaxRes],
  output logic                                dropped_o,
  output logic                                last_o
);

  localparam int ProdW = 2 * pbse_pkg::ProbW;

  logic [pbse_pkg::ResW-1:0]    res_q;
  logic [pbse_pkg::ProbW-1:0]   ip_q   [pbse_pkg::MaxItems];
  logic [pbse_pkg::WeightW-1:0] win_q  [pbse_pkg::MaxItems][pbse_pkg::MaxRes];
  logic [pbse_pkg::WeightW-1:0] loss_q [pbse_pkg::MaxItems][pbse_pkg::MaxRes];
  logic [pbse_pkg::ItemW-1:0]   cnt_q;
  logic                         ovf_q;

  logic [pbse_pkg::MaskW-1:0]   cur_mask_q;
  logic [pbse_pkg::ProbW-1:0]   acc_q;
  logic [pbse_pkg::TotalW-1:0]  tot_q [pbse_pkg::MaxRes];

  logic                         sv_q;
  logic [pbse_pkg::MaskW-1:0]   sk_q;
  logic                         best_v_q;
  logic [pbse_pkg::MaskW-1:0]   best_mask_q;
  logic [pbse_pkg::TotalW-1:0]  best_key_q;
  logic [pbse_pkg::ScenN-1:0]   emitted_q;
  logic [pbse_pkg::TotalW-1:0]  key_rd;

  logic [pbse_pkg::ResW-1:0]    eff_res;
  logic [pbse_pkg::ProbW-1:0]   p_sat;
  logic                         won;
  logic [pbse_pkg::ProbW-1:0]   fac;
  logic [ProdW-1:0]             prod;

  always_comb begin
    if (res_q == '0) begin
      eff_res = pbse_pkg::ResW'(1);
    end else if (res_q > pbse_pkg::ResW'(pbse_pkg::MaxRes)) begin
      eff_res = pbse_pkg::ResW'(pbse_pkg::MaxRes);
    end else begin
      eff_res = res_q;
    end
  end

  assign p_sat = (prob_i > pbse_pkg::ProbOne) ? pbse_pkg::ProbOne : prob_i;
  assign won   = cur_mask_q[cmd_i.item];
  assign fac   = won ? ip_q[cmd_i.item] : (pbse_pkg::ProbOne - ip_q[cmd_i.item]);
  assign prod  = ProdW'(acc_q) * ProdW'(fac);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q     <= pbse_pkg::ResW'(1);
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      sv_q      <= 1'b0;
      best_v_q  <= 1'b0;
      emitted_q <= '0;
      valid_o   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        res_q <= cfg_data_i;
      end
      if (cmd_i.run_end) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else if (cmd_i.load) begin
        if (cnt_q < pbse_pkg::ItemW'(pbse_pkg::MaxItems)) begin
          cnt_q <= cnt_q + pbse_pkg::ItemW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      sv_q <= cmd_i.scan_rd;
      if (cmd_i.scan_clr) begin
        best_v_q <= 1'b0;
      end else if (sv_q && !emitted_q[sk_q] && (!best_v_q || key_rd > best_key_q)) begin
        best_v_q <= 1'b1;
      end
      valid_o <= cmd_i.emit;
      if (cmd_i.run_end) begin
        emitted_q <= '0;
      end else if (cmd_i.emit) begin
        emitted_q[cur_mask_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && cnt_q < pbse_pkg::ItemW'(pbse_pkg::MaxItems)) begin
      ip_q[cnt_q] <= p_sat;
      for (int h = 0; h < pbse_pkg::MaxRes; h++) begin
        win_q[cnt_q][h]  <= win_i[h];
        loss_q[cnt_q][h] <= loss_i[h];
      end
    end
    if (cmd_i.calc_clr) begin
      cur_mask_q <= cmd_i.use_best ? best_mask_q : cmd_i.mask;
      acc_q      <= pbse_pkg::ProbOne;
      for (int h = 0; h < pbse_pkg::MaxRes; h++) begin
        tot_q[h] <= '0;
      end
    end else if (cmd_i.calc_step) begin
      acc_q <= prod[pbse_pkg::FracBits +: pbse_pkg::ProbW];
      for (int h = 0; h < pbse_pkg::MaxRes; h++) begin
        if (pbse_pkg::ResW'(h) < eff_res) begin
          tot_q[h] <= tot_q[h] + pbse_pkg::TotalW'(won ? win_q[cmd_i.item][h]
                                                       : loss_q[cmd_i.item][h]);
        end
      end
    end
    sk_q <= cmd_i.mask;
    if (!cmd_i.scan_clr && sv_q && !emitted_q[sk_q] &&
        (!best_v_q || key_rd > best_key_q)) begin
      best_key_q  <= key_rd;
      best_mask_q <= sk_q;
    end
    if (cmd_i.emit) begin
      mask_o    <= cur_mask_q;
      prob_o    <= acc_q;
      total_o   <= tot_q;
      dropped_o <= ovf_q;
      last_o    <= cmd_i.last;
    end
  end

  pbse_ram #(
    .Width (pbse_pkg::TotalW),
    .Depth (pbse_pkg::ScenN)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.key_wr),
    .waddr_i (cmd_i.mask),
    .wdata_i (tot_q[0]),
    .raddr_i (cmd_i.mask),
    .rdata_o (key_rd)
  );

  assign status_o.count = cnt_q;

endmodule

/* design/pbse_ctrl.sv */
module pbse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              final_i,
  input  pbse_pkg::status_t status_i,
  output logic              busy_o,
  output pbse_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SKClr   = 4'd1;
  localparam logic [3:0] SKStep  = 4'd2;
  localparam logic [3:0] SKWr    = 4'd3;
  localparam logic [3:0] SSClr   = 4'd4;
  localparam logic [3:0] SScan   = 4'd5;
  localparam logic [3:0] SSDrain = 4'd6;
  localparam logic [3:0] SCClr   = 4'd7;
  localparam logic [3:0] SCStep  = 4'd8;
  localparam logic [3:0] SEmit   = 4'd9;

  localparam int CntW = pbse_pkg::MaskW + 1;

  logic [3:0]                 state_q, state_d;
  logic [CntW-1:0]            m_q, m_d;
  logic [CntW-1:0]            r_q, r_d;
  logic [pbse_pkg::ItemW-1:0] i_q, i_d;
  logic [CntW-1:0]            last_idx;
  logic                       last_item;

  assign last_idx  = (CntW'(1) << status_i.count) - CntW'(1);
  assign last_item = (i_q == status_i.count - pbse_pkg::ItemW'(1));
  assign busy_o    = (state_q != SIdle);

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    r_d     = r_q;
    i_d     = i_q;
    cmd_o   = '0;
    cmd_o.mask = m_q[pbse_pkg::MaskW-1:0];
    cmd_o.item = i_q;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (final_i) begin
            m_d     = '0;
            state_d = SKClr;
          end
        end
      end
      SKClr: begin
        cmd_o.calc_clr = 1'b1;
        i_d            = '0;
        state_d        = (status_i.count == '0) ? SKWr : SKStep;
      end
      SKStep: begin
        cmd_o.calc_step = 1'b1;
        if (last_item) begin
          state_d = SKWr;
        end else begin
          i_d = i_q + pbse_pkg::ItemW'(1);
        end
      end
      SKWr: begin
        cmd_o.key_wr = 1'b1;
        if (m_q == last_idx) begin
          r_d     = '0;
          state_d = SSClr;
        end else begin
          m_d     = m_q + CntW'(1);
          state_d = SKClr;
        end
      end
      SSClr: begin
        cmd_o.scan_clr = 1'b1;
        m_d            = '0;
        state_d        = SScan;
      end
      SScan: begin
        cmd_o.scan_rd = 1'b1;
        if (m_q == last_idx) begin
          state_d = SSDrain;
        end else begin
          m_d = m_q + CntW'(1);
        end
      end
      SSDrain: begin
        state_d = SCClr;
      end
      SCClr: begin
        cmd_o.calc_clr = 1'b1;
        cmd_o.use_best = 1'b1;
        i_d            = '0;
        state_d        = (status_i.count == '0) ? SEmit : SCStep;
      end
      SCStep: begin
        cmd_o.calc_step = 1'b1;
        if (last_item) begin
          state_d = SEmit;
        end else begin
          i_d = i_q + pbse_pkg::ItemW'(1);
        end
      end
      SEmit: begin
        cmd_o.emit = 1'b1;
        cmd_o.last = (r_q == last_idx);
        if (r_q == last_idx) begin
          cmd_o.run_end = 1'b1;
          state_d       = SIdle;
        end else begin
          r_d     = r_q + CntW'(1);
          state_d = SSClr;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      m_q     <= '0;
      r_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      m_q     <= m_d;
      r_q     <= r_d;
      i_q     <= i_d;
    end
  end

endmodule

/* design/poisson_binomial_scenario_enum.sv */
// Scenario enumerator over up to six Bernoulli items.
// Item channel: present an item with start high; it is taken at an edge where
// start is high and busy is low. Items without final_item are stored and busy
// stays low. Items past the sixth are dropped and flagged.
// The item carrying final_item starts a run: busy rises and stays high until
// all 2^n scenarios have been delivered, where n is the stored item count.
// Results: each scenario shows for one cycle with result_valid_o high; the
// receiver cannot stall, so nothing is held. Scenarios come out by resource 0
// total descending, ties in ascending mask order; last_scenario_o marks the end.
// Sequence: a key pass writes the resource 0 total of every scenario into the
// key RAM; then per scenario a scan of the key RAM (one read port) and a rebuild
// of the chosen scenario on the shared 17x17 multiply/add unit.
// Config: cfg_valid_i writes active_resources at any edge (cfg_ready_o is
// always high); write it only while idle.
// Reset: store empty, drop flag clear, active_resources = 1, block idle.
module poisson_binomial_scenario_enum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [16:0] success_probability_i,
  input  logic [15:0] win_weight_0_i,
  input  logic [15:0] win_weight_1_i,
  input  logic [15:0] win_weight_2_i,
  input  logic [15:0] win_weight_3_i,
  input  logic [15:0] loss_weight_0_i,
  input  logic [15:0] loss_weight_1_i,
  input  logic [15:0] loss_weight_2_i,
  input  logic [15:0] loss_weight_3_i,
  input  logic        final_item_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [5:0]  scenario_mask_o,
  output logic [16:0] scenario_probability_o,
  output logic [18:0] total_resource_0_o,
  output logic [18:0] total_resource_1_o,
  output logic [18:0] total_resource_2_o,
  output logic [18:0] total_resource_3_o,
  output logic        items_dropped_o,
  output logic        last_scenario_o
);

  pbse_pkg::cmd_t    cmd;
  pbse_pkg::status_t status;

  logic [pbse_pkg::WeightW-1:0] win  [pbse_pkg::MaxRes];
  logic [pbse_pkg::WeightW-1:0] loss [pbse_pkg::MaxRes];
  logic [pbse_pkg::TotalW-1:0]  total [pbse_pkg::MaxRes];

  // Gather the per-resource weights into lanes
  assign win[0]  = win_weight_0_i;
  assign win[1]  = win_weight_1_i;
  assign win[2]  = win_weight_2_i;
  assign win[3]  = win_weight_3_i;
  assign loss[0] = loss_weight_0_i;
  assign loss[1] = loss_weight_1_i;
  assign loss[2] = loss_weight_2_i;
  assign loss[3] = loss_weight_3_i;

  // Config register is always writable
  assign cfg_ready_o = 1'b1;

  pbse_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .final_i  (final_item_i),
    .status_i (status),
    .busy_o   (busy),
    .cmd_o    (cmd)
  );

  pbse_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .prob_i     (success_probability_i),
    .win_i      (win),
    .loss_i     (loss),
    .valid_o    (result_valid_o),
    .mask_o     (scenario_mask_o),
    .prob_o     (scenario_probability_o),
    .total_o    (total),
    .dropped_o  (items_dropped_o),
    .last_o     (last_scenario_o)
  );

  assign total_resource_0_o = total[0];
  assign total_resource_1_o = total[1];
  assign total_resource_2_o = total[2];
  assign total_resource_3_o = total[3];

endmodule

/* design/pbse_checker.sv */
module pbse_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic final_item_i,
  input logic result_valid_o,
  input logic last_scenario_o
);

  // A result only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a running enumeration");

  // Results never come out back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back results");

  // A final item starts a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && final_item_i) |=> busy)
    else $error("final item did not start a run");

  // A non-final item is stored without a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !final_item_i) |=> !busy)
    else $error("non-final item left the block busy");

  // After the last scenario the block is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_scenario_o) |-> !busy)
    else $error("still busy after the last scenario");

endmodule

bind poisson_binomial_scenario_enum pbse_checker u_pbse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .final_item_i    (final_item_i),
  .result_valid_o  (result_valid_o),
  .last_scenario_o (last_scenario_o)
);
